[sv/sha1_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types, constants and the command bundle of the SHA-1 engine.
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam int NUM_WORDS   = 5;
    localparam int BLOCK_BYTES = 64;
    localparam int ROUNDS      = 80;

    localparam logic [4:0][31:0] H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [31:0] K_STAGE0 = 32'h5A827999;
    localparam logic [31:0] K_STAGE1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_STAGE2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_STAGE3 = 32'hCA62C1D6;

    localparam logic [5:0] LAST_POS   = 6'd63;
    localparam logic [5:0] LENGTH_POS = 6'd56;
    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [2:0] LAST_WORD  = 3'd4;
    localparam logic [2:0] LAST_LEN   = 3'd7;

    typedef enum logic [1:0] {
        SRC_MSG,
        SRC_PAD80,
        SRC_ZERO,
        SRC_LEN
    } byte_src_t;

    typedef enum logic [1:0] {
        STG_CH,
        STG_PAR1,
        STG_MAJ,
        STG_PAR2
    } round_stage_t;

    typedef struct packed {
        logic         shift_en;
        byte_src_t    byte_src;
        logic [2:0]   len_idx;
        logic         count_en;
        logic         load_work;
        logic         round_en;
        round_stage_t stage;
        logic         finish_en;
        logic         chain_init;
        logic         out_load;
        logic [2:0]   out_idx;
    } dp_cmd_t;

endpackage

[sv/sha1_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_datapath
// Block shift line, message schedule, round logic, chain value, bit count
// and digest output register.
// ----------------------------------------------------------------------------
module sha1_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  sha1_pkg::dp_cmd_t  cmd,
    input  logic [7:0]         message_byte,
    output logic [31:0]        digest_word,
    output logic [2:0]         word_number,
    output logic               final_word
);

    logic [511:0]      blk_reg, blk_next;
    logic [31:0]       a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [4:0][31:0]  chain_reg, chain_next;
    logic [63:0]       bit_count_reg, bit_count_next;
    logic [31:0]       digest_word_reg;
    logic [2:0]        word_number_reg;
    logic              final_word_reg;

    logic [7:0]        byte_in;
    logic [31:0]       w0;
    logic [31:0]       sched_x;
    logic [31:0]       sched_w;
    logic [31:0]       f_val;
    logic [31:0]       k_val;
    logic [31:0]       t_val;

    always_comb
    begin
        case (cmd.byte_src)
            sha1_pkg::SRC_MSG:   byte_in = message_byte;
            sha1_pkg::SRC_PAD80: byte_in = 8'h80;
            sha1_pkg::SRC_ZERO:  byte_in = 8'h00;
            sha1_pkg::SRC_LEN:   byte_in = bit_count_reg[{~cmd.len_idx, 3'b111} -: 8];
            default:             byte_in = 8'h00;
        endcase
    end

    assign w0      = blk_reg[511:480];
    assign sched_x = blk_reg[95:64] ^ blk_reg[255:224] ^ blk_reg[447:416] ^ w0;
    assign sched_w = {sched_x[30:0], sched_x[31]};

    always_comb
    begin
        case (cmd.stage)
            sha1_pkg::STG_CH:
            begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                k_val = sha1_pkg::K_STAGE0;
            end
            sha1_pkg::STG_PAR1:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = sha1_pkg::K_STAGE1;
            end
            sha1_pkg::STG_MAJ:
            begin
                f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
                k_val = sha1_pkg::K_STAGE2;
            end
            default:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = sha1_pkg::K_STAGE3;
            end
        endcase
    end

    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w0;

    always_comb
    begin
        blk_next = blk_reg;
        if (cmd.shift_en)
        begin
            blk_next = {blk_reg[503:0], byte_in};
        end
        else if (cmd.round_en)
        begin
            blk_next = {blk_reg[479:0], sched_w};
        end
    end

    always_comb
    begin
        chain_next = chain_reg;
        if (cmd.chain_init)
        begin
            chain_next = sha1_pkg::H_INIT;
        end
        else if (cmd.finish_en)
        begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
            chain_next[4] = chain_reg[4] + e_reg;
        end
    end

    always_comb
    begin
        bit_count_next = bit_count_reg;
        if (cmd.chain_init)
        begin
            bit_count_next = 64'd0;
        end
        else if (cmd.count_en)
        begin
            bit_count_next = bit_count_reg + 64'd8;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg     <= sha1_pkg::H_INIT;
            bit_count_reg <= 64'd0;
        end
        else
        begin
            chain_reg     <= chain_next;
            bit_count_reg <= bit_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        if (cmd.load_work)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end
        else if (cmd.round_en)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
        if (cmd.out_load)
        begin
            digest_word_reg <= chain_reg[cmd.out_idx];
            word_number_reg <= cmd.out_idx;
            final_word_reg  <= (cmd.out_idx == sha1_pkg::LAST_WORD);
        end
    end

    assign digest_word = digest_word_reg;
    assign word_number = word_number_reg;
    assign final_word  = final_word_reg;

endmodule

[sv/sha1_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_ctrl
// Sequencer for byte intake, compression rounds, padding and digest output.
// ----------------------------------------------------------------------------
module sha1_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               byte_present,
    input  logic               end_of_message,
    output logic               out_valid,
    input  logic               out_ready,
    output sha1_pkg::dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_FINISH,
        S_PAD80,
        S_ZERO,
        S_LEN,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        RET_IDLE,
        RET_PAD80,
        RET_ZERO,
        RET_EMIT
    } ret_t;

    state_t     state_reg, state_next;
    ret_t       ret_reg, ret_next;
    logic [6:0] rnd_reg, rnd_next;
    logic [5:0] pos_reg, pos_next;
    logic       wrap_reg, wrap_next;
    logic [2:0] len_reg, len_next;
    logic [2:0] wcnt_reg, wcnt_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        rnd_next       = rnd_reg;
        pos_next       = pos_reg;
        wrap_next      = wrap_reg;
        len_next       = len_reg;
        wcnt_next      = wcnt_reg;
        out_valid_next = out_valid_reg && !out_ready;

        cmd            = '0;
        cmd.byte_src   = sha1_pkg::SRC_ZERO;
        cmd.len_idx    = len_reg;
        cmd.out_idx    = wcnt_reg;
        if (rnd_reg < 7'd20)
        begin
            cmd.stage = sha1_pkg::STG_CH;
        end
        else if (rnd_reg < 7'd40)
        begin
            cmd.stage = sha1_pkg::STG_PAR1;
        end
        else if (rnd_reg < 7'd60)
        begin
            cmd.stage = sha1_pkg::STG_MAJ;
        end
        else
        begin
            cmd.stage = sha1_pkg::STG_PAR2;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (byte_present)
                    begin
                        cmd.shift_en = 1'b1;
                        cmd.byte_src = sha1_pkg::SRC_MSG;
                        cmd.count_en = 1'b1;
                        pos_next     = pos_reg + 6'd1;
                        if (pos_reg == sha1_pkg::LAST_POS)
                        begin
                            cmd.load_work = 1'b1;
                            rnd_next      = 7'd0;
                            state_next    = S_ROUND;
                            ret_next      = end_of_message ? RET_PAD80 : RET_IDLE;
                        end
                        else if (end_of_message)
                        begin
                            state_next = S_PAD80;
                        end
                    end
                    else if (end_of_message)
                    begin
                        state_next = S_PAD80;
                    end
                end
            end
            S_ROUND:
            begin
                cmd.round_en = 1'b1;
                rnd_next     = rnd_reg + 7'd1;
                if (rnd_reg == sha1_pkg::LAST_ROUND)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.finish_en = 1'b1;
                case (ret_reg)
                    RET_IDLE:  state_next = S_IDLE;
                    RET_PAD80: state_next = S_PAD80;
                    RET_ZERO:  state_next = S_ZERO;
                    RET_EMIT:  state_next = S_EMIT;
                    default:   state_next = S_IDLE;
                endcase
            end
            S_PAD80:
            begin
                cmd.shift_en = 1'b1;
                cmd.byte_src = sha1_pkg::SRC_PAD80;
                pos_next     = pos_reg + 6'd1;
                wrap_next    = (pos_reg >= sha1_pkg::LENGTH_POS);
                if (pos_reg == sha1_pkg::LAST_POS)
                begin
                    cmd.load_work = 1'b1;
                    rnd_next      = 7'd0;
                    wrap_next     = 1'b0;
                    ret_next      = RET_ZERO;
                    state_next    = S_ROUND;
                end
                else
                begin
                    state_next = S_ZERO;
                end
            end
            S_ZERO:
            begin
                if (!wrap_reg && (pos_reg == sha1_pkg::LENGTH_POS))
                begin
                    len_next   = 3'd0;
                    state_next = S_LEN;
                end
                else
                begin
                    cmd.shift_en = 1'b1;
                    cmd.byte_src = sha1_pkg::SRC_ZERO;
                    pos_next     = pos_reg + 6'd1;
                    if (pos_reg == sha1_pkg::LAST_POS)
                    begin
                        cmd.load_work = 1'b1;
                        rnd_next      = 7'd0;
                        wrap_next     = 1'b0;
                        ret_next      = RET_ZERO;
                        state_next    = S_ROUND;
                    end
                end
            end
            S_LEN:
            begin
                cmd.shift_en = 1'b1;
                cmd.byte_src = sha1_pkg::SRC_LEN;
                pos_next     = pos_reg + 6'd1;
                len_next     = len_reg + 3'd1;
                if (len_reg == sha1_pkg::LAST_LEN)
                begin
                    cmd.load_work = 1'b1;
                    rnd_next      = 7'd0;
                    wcnt_next     = 3'd0;
                    ret_next      = RET_EMIT;
                    state_next    = S_ROUND;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    wcnt_next      = wcnt_reg + 3'd1;
                    if (wcnt_reg == sha1_pkg::LAST_WORD)
                    begin
                        cmd.chain_init = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= RET_IDLE;
            rnd_reg       <= 7'd0;
            pos_reg       <= 6'd0;
            wrap_reg      <= 1'b0;
            len_reg       <= 3'd0;
            wcnt_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            rnd_reg       <= rnd_next;
            pos_reg       <= pos_next;
            wrap_reg      <= wrap_next;
            len_reg       <= len_next;
            wcnt_reg      <= wcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[sv/sha1_hash_engine_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_hash_engine_unit
// Streaming SHA-1 engine: one byte per input transaction, five digest words
// per message.
// ----------------------------------------------------------------------------
//  Channel  Handshake            Payload
//  input    in_valid/in_ready    message_byte, byte_present, end_of_message
//  output   out_valid/out_ready  digest_word, word_number, final_word
//
// A byte is taken while the engine is idle; every 64th byte holds off input for
// the 80 rounds of the shared round unit and the chain update.
// A final transaction adds padding bytes up to the length field, 8 length
// bytes, one or two compressions, and the emission of 5 digest words.
// Reset is immediate; no clearing pass is needed.
// The output register holds a digest word while the next message is taken in;
// a stalled output holds only the digest emission.
// ----------------------------------------------------------------------------
module sha1_hash_engine_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  message_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_number,
    output logic        final_word
);

    sha1_pkg::dp_cmd_t cmd;

    sha1_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cmd            (cmd)
    );

    sha1_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .message_byte (message_byte),
        .digest_word  (digest_word),
        .word_number  (word_number),
        .final_word   (final_word)
    );

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("Digest word loaded but output not valid.");

    a_final_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (final_word == (word_number == sha1_pkg::LAST_WORD)))
        else $error("Final word flag does not match word number.");

    a_init_with_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.chain_init |-> (cmd.out_load && (cmd.out_idx == sha1_pkg::LAST_WORD)))
        else $error("Chain reinitialized before the last digest word.");

    a_no_round_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!cmd.round_en && !cmd.finish_en))
        else $error("Input ready during compression.");

endmodule
